>>> hw/rtl/bcf_pkg.sv
// Package for the bracketed command framer.
// Holds the character codes, the register reset value and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package bcf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 16;

    localparam logic [BYTE_W-1:0] CH_OPEN_FRAME = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [BYTE_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH     = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;

    localparam logic [POS_W-1:0] MAX_LEN_RESET = 16'd511;
    localparam logic [POS_W-1:0] DEPTH_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  frame_pos;
        logic              frame_last;
        logic              frame_abort;
    } bcf_result_t;

endpackage

>>> hw/rtl/bcf_in_stage.sv
// Input register of the bracketed command framer.
// Captures one received word per cycle while s_ready is high; depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bcf_pkg::BYTE_W-1:0]  s_rx_byte,
    input  logic                        advance,
    output logic                        in_valid,
    output logic [bcf_pkg::BYTE_W-1:0]  in_byte
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [bcf_pkg::BYTE_W-1:0] byte_reg;
    logic                       load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

>>> hw/rtl/bcf_framer.sv
// Frame tracking logic: frame, quote, escape, nesting and length state.
// Holds the length limit register; depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_framer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bcf_pkg::POS_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    input  logic [bcf_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        advance,
    output logic                        res_valid,
    output bcf_pkg::bcf_result_t        res
);

    logic [bcf_pkg::POS_W-1:0] max_len_reg;

    logic                      in_frame_reg, in_frame_next;
    logic                      in_quote_reg, in_quote_next;
    logic                      escape_pending_reg, escape_pending_next;
    logic [bcf_pkg::POS_W-1:0] nest_depth_reg, nest_depth_next;
    logic [bcf_pkg::POS_W-1:0] byte_count_reg, byte_count_next;

    logic                      quote_cur;
    logic                      escape_cur;
    logic [bcf_pkg::POS_W-1:0] depth_cur;
    logic [bcf_pkg::POS_W-1:0] count_cur;
    logic [bcf_pkg::POS_W-1:0] depth_dec;
    logic                      last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= bcf_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        in_frame_next       = in_frame_reg;
        in_quote_next       = in_quote_reg;
        escape_pending_next = escape_pending_reg;
        nest_depth_next     = nest_depth_reg;
        byte_count_next     = byte_count_reg;
        res_valid           = 1'b0;
        last                = 1'b0;
        depth_dec           = '0;
        res.out_byte        = in_byte;
        res.frame_pos       = '0;
        res.frame_last      = 1'b0;
        res.frame_abort     = 1'b0;

        // A new frame starts from cleared state.
        quote_cur  = in_frame_reg ? in_quote_reg : 1'b0;
        escape_cur = in_frame_reg ? escape_pending_reg : 1'b0;
        depth_cur  = in_frame_reg ? nest_depth_reg : '0;
        count_cur  = in_frame_reg ? byte_count_reg : '0;

        if (in_valid && (in_frame_reg || in_byte == bcf_pkg::CH_OPEN_FRAME)) begin
            in_frame_next       = 1'b1;
            in_quote_next       = quote_cur;
            escape_pending_next = escape_cur;
            nest_depth_next     = depth_cur;
            byte_count_next     = count_cur;
            if (in_byte inside {bcf_pkg::CH_CR, bcf_pkg::CH_LF}) begin
                res_valid = 1'b0;
            end else if (count_cur >= max_len_reg) begin
                res_valid           = 1'b1;
                res.frame_pos       = count_cur;
                res.frame_abort     = 1'b1;
                in_frame_next       = 1'b0;
                in_quote_next       = 1'b0;
                escape_pending_next = 1'b0;
                nest_depth_next     = '0;
                byte_count_next     = '0;
            end else begin
                res_valid       = 1'b1;
                res.frame_pos   = count_cur;
                byte_count_next = count_cur + 1'b1;
                if (escape_cur) begin
                    escape_pending_next = 1'b0;
                end else if (in_byte == bcf_pkg::CH_BSLASH && quote_cur) begin
                    escape_pending_next = 1'b1;
                end else if (in_byte == bcf_pkg::CH_QUOTE) begin
                    in_quote_next = !quote_cur;
                end else if (!quote_cur) begin
                    if (in_byte == bcf_pkg::CH_LPAREN) begin
                        if (depth_cur != bcf_pkg::DEPTH_MAX) begin
                            nest_depth_next = depth_cur + 1'b1;
                        end
                    end else if (in_byte == bcf_pkg::CH_RPAREN) begin
                        depth_dec       = (depth_cur != '0) ? depth_cur - 1'b1 : '0;
                        nest_depth_next = depth_dec;
                        last            = (depth_dec == '0);
                    end
                end
                res.frame_last = last;
                if (last) begin
                    in_frame_next       = 1'b0;
                    in_quote_next       = 1'b0;
                    escape_pending_next = 1'b0;
                    nest_depth_next     = '0;
                    byte_count_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg       <= 1'b0;
            in_quote_reg       <= 1'b0;
            escape_pending_reg <= 1'b0;
            nest_depth_reg     <= '0;
            byte_count_reg     <= '0;
        end else if (advance) begin
            in_frame_reg       <= in_frame_next;
            in_quote_reg       <= in_quote_next;
            escape_pending_reg <= escape_pending_next;
            nest_depth_reg     <= nest_depth_next;
            byte_count_reg     <= byte_count_next;
        end
    end

    a_hunt_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (byte_count_reg == '0 && nest_depth_reg == '0 &&
                           !in_quote_reg && !escape_pending_reg))
        else $error("State not cleared while hunting");

    a_escape_in_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        escape_pending_reg |-> in_quote_reg)
        else $error("Escape pending outside quotes");

    a_last_not_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.frame_last && res.frame_abort))
        else $error("Word marked both last and abort");

    a_end_resumes_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid && (res.frame_last || res.frame_abort)) |=> !in_frame_reg)
        else $error("Frame still open after it ended");

endmodule

>>> hw/rtl/bcf_out_stage.sv
// Result register of the bracketed command framer.
// Holds one result word until the consumer takes it; depends on bcf_pkg.
`timescale 1ns / 1ps

module bcf_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  bcf_pkg::bcf_result_t        res,
    output logic                        out_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcf_pkg::BYTE_W-1:0]  m_out_byte,
    output logic [bcf_pkg::POS_W-1:0]   m_frame_pos,
    output logic                        m_frame_last,
    output logic                        m_frame_abort
);

    logic                 valid_reg;
    logic                 valid_next;
    bcf_pkg::bcf_result_t data_reg;

    assign out_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = data_reg.out_byte;
    assign m_frame_pos   = data_reg.frame_pos;
    assign m_frame_last  = data_reg.frame_last;
    assign m_frame_abort = data_reg.frame_abort;

endmodule

>>> hw/rtl/bracketed_command_framer_unit.sv
// A word with a result passes the input register, then the result register, to reach the m_ side.
// Throughput: one word per cycle while m_ready is high; input and result registers advance together.
// Line breaks and bytes outside a frame are absorbed without a result.
// Reset (aresetn low, synchronous) empties both registers, resumes hunting for '<'
// and sets the length limit to 511.
`timescale 1ns / 1ps

module bracketed_command_framer_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [bcf_pkg::POS_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bcf_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bcf_pkg::BYTE_W-1:0]  m_out_byte,
    output logic [bcf_pkg::POS_W-1:0]   m_frame_pos,
    output logic                        m_frame_last,
    output logic                        m_frame_abort
);

    logic                       in_valid;
    logic [bcf_pkg::BYTE_W-1:0] in_byte;
    logic                       out_ready;
    logic                       advance;
    logic                       res_valid;
    bcf_pkg::bcf_result_t       res;

    assign advance = in_valid && out_ready;

    bcf_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .advance   (advance),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    bcf_framer u_framer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .advance     (advance),
        .res_valid   (res_valid),
        .res         (res)
    );

    bcf_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && res_valid),
        .res           (res),
        .out_ready     (out_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_pos   (m_frame_pos),
        .m_frame_last  (m_frame_last),
        .m_frame_abort (m_frame_abort)
    );

endmodule

>>> tb/sv/bracketed_command_framer_unit_test.sv
// Self-checking testbench for bracketed_command_framer_unit: drives received bytes,
// predicts each framed word with its own model and compares every result field by field.
// Depends on bcf_pkg and the bracketed_command_framer_unit RTL.
`timescale 1ns / 1ps

module bracketed_command_framer_unit_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 92;
    localparam int DRAIN_CYCLES = 4;

    logic                       aclk;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [bcf_pkg::POS_W-1:0]  cfg_wr_data   = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [bcf_pkg::BYTE_W-1:0] s_rx_byte     = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [bcf_pkg::BYTE_W-1:0] m_out_byte;
    logic [bcf_pkg::POS_W-1:0]  m_frame_pos;
    logic                       m_frame_last;
    logic                       m_frame_abort;

    logic [bcf_pkg::BYTE_W-1:0] pending_bytes[$];
    bcf_pkg::bcf_result_t       expected_words[$];
    bcf_pkg::bcf_result_t       want;
    bit                         word_sent     = 1'b0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;
    int                         mismatches    = 0;
    int                         stall_cycles  = 0;
    int                         frame_bytes_queued = 0;

    // Predictor state.
    bit                         frame_open = 1'b0;
    bit                         quoted     = 1'b0;
    bit                         escaped    = 1'b0;
    logic [bcf_pkg::POS_W-1:0]  nest_level = '0;
    logic [bcf_pkg::POS_W-1:0]  byte_count = '0;
    logic [bcf_pkg::POS_W-1:0]  len_limit  = bcf_pkg::MAX_LEN_RESET;

    bracketed_command_framer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_pos   (m_frame_pos),
        .m_frame_last  (m_frame_last),
        .m_frame_abort (m_frame_abort)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void clear_frame_state();
        quoted     = 1'b0;
        escaped    = 1'b0;
        nest_level = '0;
        byte_count = '0;
    endfunction

    function automatic void frame_rx_byte(input logic [bcf_pkg::BYTE_W-1:0] ch);
        bcf_pkg::bcf_result_t word;
        logic                 closing;
        closing = 1'b0;
        if (!frame_open) begin
            if (ch != bcf_pkg::CH_OPEN_FRAME) return;
            frame_open = 1'b1;
            clear_frame_state();
        end
        if (ch == bcf_pkg::CH_CR || ch == bcf_pkg::CH_LF) return;
        word.out_byte  = ch;
        word.frame_pos = byte_count;
        if (byte_count >= len_limit) begin
            word.frame_last  = 1'b0;
            word.frame_abort = 1'b1;
            expected_words.push_back(word);
            frame_open = 1'b0;
            clear_frame_state();
            return;
        end
        byte_count = byte_count + 1'b1;
        if (escaped) begin
            escaped = 1'b0;
        end else if (ch == bcf_pkg::CH_BSLASH && quoted) begin
            escaped = 1'b1;
        end else if (ch == bcf_pkg::CH_QUOTE) begin
            quoted = !quoted;
        end else if (!quoted) begin
            if (ch == bcf_pkg::CH_LPAREN) begin
                if (nest_level != bcf_pkg::DEPTH_MAX) nest_level = nest_level + 1'b1;
            end else if (ch == bcf_pkg::CH_RPAREN) begin
                if (nest_level != 0) nest_level = nest_level - 1'b1;
                if (nest_level == 0) closing = 1'b1;
            end
        end
        word.frame_last  = closing;
        word.frame_abort = 1'b0;
        expected_words.push_back(word);
        if (closing) begin
            frame_open = 1'b0;
            clear_frame_state();
        end
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!s_valid || word_sent) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid   <= 1'b1;
                s_rx_byte <= pending_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        word_sent = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected word: byte %02h pos %0d last %b abort %b",
                                 m_out_byte, m_frame_pos, m_frame_last, m_frame_abort);
                end else begin
                    want = expected_words.pop_front();
                    if (want.out_byte !== m_out_byte || want.frame_pos !== m_frame_pos ||
                        want.frame_last !== m_frame_last ||
                        want.frame_abort !== m_frame_abort) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("Mismatch: expected byte %02h pos %0d last %b abort %b, ",
                                   want.out_byte, want.frame_pos, want.frame_last,
                                   want.frame_abort);
                            $display("got byte %02h pos %0d last %b abort %b",
                                     m_out_byte, m_frame_pos, m_frame_last, m_frame_abort);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                frame_rx_byte(s_rx_byte);
                word_sent = 1'b1;
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_valid || expected_words.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [bcf_pkg::POS_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        len_limit = value;
    endtask

    task automatic push_byte(input logic [bcf_pkg::BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        frame_bytes_queued++;
    endtask

    task automatic push_noise();
        int n;
        n = $urandom_range(3, 0);
        repeat (n) pending_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Builds a mostly well-formed frame; about one in eight is left unclosed.
    task automatic push_frame();
        int                         body_len;
        int                         r;
        int                         depth;
        int                         closers;
        bit                         in_q;
        bit                         esc;
        logic [bcf_pkg::BYTE_W-1:0] b;
        r        = $urandom_range(99);
        body_len = (r < 5) ? $urandom_range(200, 60) : $urandom_range(20, 0);
        depth    = 0;
        in_q     = 1'b0;
        esc      = 1'b0;
        push_byte(bcf_pkg::CH_OPEN_FRAME);
        for (int i = 0; i < body_len; i++) begin
            r = $urandom_range(99);
            if (esc) begin
                b   = 8'($urandom_range(255));
                esc = 1'b0;
            end else if (r < 12) begin
                b = bcf_pkg::CH_LPAREN;
                if (!in_q) depth++;
            end else if (r < 20 && (in_q || depth > 1)) begin
                b = bcf_pkg::CH_RPAREN;
                if (!in_q) depth--;
            end else if (r < 28) begin
                b    = bcf_pkg::CH_QUOTE;
                in_q = !in_q;
            end else if (r < 33) begin
                b = bcf_pkg::CH_BSLASH;
                if (in_q) esc = 1'b1;
            end else if (r < 38) begin
                b = r[0] ? bcf_pkg::CH_CR : bcf_pkg::CH_LF;
            end else begin
                b = 8'($urandom_range(255));
                if (b == bcf_pkg::CH_LPAREN || b == bcf_pkg::CH_RPAREN ||
                    b == bcf_pkg::CH_QUOTE || b == bcf_pkg::CH_BSLASH)
                    b = 8'h41;
            end
            push_byte(b);
        end
        if ($urandom_range(99) >= 12) begin
            if (esc) push_byte(8'h7A);
            if (in_q) push_byte(bcf_pkg::CH_QUOTE);
            closers = (depth == 0) ? 1 : depth;
            repeat (closers) push_byte(bcf_pkg::CH_RPAREN);
        end
    endtask

    task automatic set_idling(input int phase);
        if (phase < 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 70;
        end else if (phase < 6) begin
            send_idle_pct = 70;
            recv_idle_pct = 26;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    initial begin
        logic [bcf_pkg::POS_W-1:0] limits[8];
        limits = '{16'd65535, 16'd3, 16'd2, 16'd24, 16'd511, 16'd1, 16'd100, 16'd0};
        limits[6] = 16'($urandom_range(400, 5));
        set_idling(0);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Bytes outside a frame, then quoting, escape and nesting with line breaks.
        pending_bytes = '{8'h00, 8'hFF, bcf_pkg::CH_RPAREN, bcf_pkg::CH_CR,
                          bcf_pkg::CH_OPEN_FRAME, 8'h00, bcf_pkg::CH_CR, bcf_pkg::CH_LF,
                          bcf_pkg::CH_LPAREN, bcf_pkg::CH_QUOTE,
                          bcf_pkg::CH_LPAREN, bcf_pkg::CH_BSLASH, bcf_pkg::CH_QUOTE,
                          bcf_pkg::CH_RPAREN, bcf_pkg::CH_QUOTE,
                          bcf_pkg::CH_BSLASH, bcf_pkg::CH_RPAREN,
                          bcf_pkg::CH_OPEN_FRAME, bcf_pkg::CH_RPAREN};
        wait_drained();

        // With a limit of one byte, the second counted byte of a frame aborts it.
        write_limit(16'd1);
        pending_bytes = '{bcf_pkg::CH_OPEN_FRAME, 8'hFF, bcf_pkg::CH_OPEN_FRAME,
                          bcf_pkg::CH_CR, bcf_pkg::CH_RPAREN};
        wait_drained();

        for (int phase = 0; phase < 8; phase++) begin
            write_limit(limits[phase]);
            set_idling(phase);
            frame_bytes_queued = 0;
            while (frame_bytes_queued < PHASE_WORDS) begin
                if ($urandom_range(99) < 40) push_noise();
                push_frame();
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
